// ===== sv/tea_pkg.sv =====
// Package for the TEA block cipher: widths, round count, key and control types,
// and the round mixing function. No dependencies.
`default_nettype none

package tea_pkg;

  localparam int unsigned ROUNDS    = 32;
  localparam int unsigned STAGES    = 2 * ROUNDS;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned KEY_WORDS = 4;
  localparam int unsigned CFG_IDX_W = $clog2(KEY_WORDS);
  localparam int unsigned SHL       = 4;
  localparam int unsigned SHR       = 5;
  localparam logic [WORD_W-1:0] DELTA = 32'h9E3779B9;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [KEY_WORDS-1:0][WORD_W-1:0] key_t;

  typedef enum logic {
    ACT_ENCRYPT = 1'b0,
    ACT_DECRYPT = 1'b1
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY0 = 2'd0,
    REG_KEY1 = 2'd1,
    REG_KEY2 = 2'd2,
    REG_KEY3 = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic    valid;
    action_t action;
  } stage_ctl_t;

  function automatic word_t round_sum(int unsigned n);
    logic [2*WORD_W-1:0] p;
    p = (2*WORD_W)'(DELTA) * (2*WORD_W)'(n);
    return p[WORD_W-1:0];
  endfunction

  function automatic word_t mix(word_t x, word_t sum, word_t ka, word_t kb);
    return ((x << SHL) + ka) ^ (x + sum) ^ ((x >> SHR) + kb);
  endfunction

endpackage

`default_nettype wire

// ===== sv/tea_in_if.sv =====
// Input channel of the TEA block cipher: valid, ready and one block to process.
// Depends on tea_pkg for the word type.
`default_nettype none

interface tea_in_if;
  logic           valid;
  logic           ready;
  logic           action;
  tea_pkg::word_t block_left;
  tea_pkg::word_t block_right;

  modport source (output valid, output action, output block_left, output block_right,
                  input ready);
  modport sink (input valid, input action, input block_left, input block_right,
                output ready);
endinterface

`default_nettype wire

// ===== sv/tea_out_if.sv =====
// Output channel of the TEA block cipher: valid, ready and one processed block.
// Depends on tea_pkg for the word type.
`default_nettype none

interface tea_out_if;
  logic           valid;
  logic           ready;
  tea_pkg::word_t result_left;
  tea_pkg::word_t result_right;

  modport source (output valid, output result_left, output result_right, input ready);
  modport sink (input valid, input result_left, input result_right, output ready);
endinterface

`default_nettype wire

// ===== sv/tea_block_cipher.sv =====
// Top level of the TEA block cipher: key registers, half-round pipeline, output skid register.
// Depends on tea_pkg, tea_in_if, tea_out_if and tea_stage.
//
//   port    dir   kind          contents
//   din     in    valid/ready   action, block_left, block_right
//   dout    out   valid/ready   result_left, result_right
//   cfg_*   in    write only    key_word0..key_word3 at index 0..3
//
// Each block passes 2*ROUNDS register stages, one half round each; one beat is
// taken per cycle while the skid register is empty.
// Reset clears the stage valid bits, the skid full flag and the key words.
// When dout stalls, the last result parks in the skid register and din.ready
// drops in the next cycle, freezing the whole pipeline until the skid drains.
`default_nettype none

module tea_block_cipher (
  input  logic                          clk,
  input  logic                          rst,
  tea_in_if.sink                        din,
  tea_out_if.source                     dout,
  input  logic                          cfg_we,
  input  logic [tea_pkg::CFG_IDX_W-1:0] cfg_index,
  input  tea_pkg::word_t                cfg_data
);
  import tea_pkg::*;

  key_t       key;
  logic       en;
  logic       skid_full;
  word_t      skid_left;
  word_t      skid_right;
  stage_ctl_t ctl_s [STAGES+1];
  word_t      y_s   [STAGES+1];
  word_t      z_s   [STAGES+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_KEY0: key[0] <= cfg_data;
        REG_KEY1: key[1] <= cfg_data;
        REG_KEY2: key[2] <= cfg_data;
        REG_KEY3: key[3] <= cfg_data;
        default:  key    <= key;
      endcase
    end
  end

  assign en        = !skid_full;
  assign din.ready = en;

  assign ctl_s[0] = '{valid: din.valid, action: action_t'(din.action)};
  assign y_s[0]   = din.block_left;
  assign z_s[0]   = din.block_right;

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    localparam int unsigned RND = s / 2;

    tea_stage u_stage (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .ctl_in  (ctl_s[s]),
      .y_in    (y_s[s]),
      .z_in    (z_s[s]),
      .key     (key),
      .sum_enc (round_sum(RND + 1)),
      .sum_dec (round_sum(ROUNDS - RND)),
      .odd     (1'(s % 2)),
      .ctl     (ctl_s[s+1]),
      .y       (y_s[s+1]),
      .z       (z_s[s+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_full <= 1'b0;
    end else if (skid_full && dout.ready) begin
      skid_full <= 1'b0;
    end else if (!skid_full && ctl_s[STAGES].valid && !dout.ready) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_full) begin
      skid_left  <= y_s[STAGES];
      skid_right <= z_s[STAGES];
    end
  end

  assign dout.valid        = skid_full || ctl_s[STAGES].valid;
  assign dout.result_left  = skid_full ? skid_left : y_s[STAGES];
  assign dout.result_right = skid_full ? skid_right : z_s[STAGES];

endmodule

`default_nettype wire

// ===== sv/tea_stage.sv =====
// One registered half round of TEA, for either direction.
// Depends on tea_pkg for types and the mixing function.
`default_nettype none

module tea_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  tea_pkg::stage_ctl_t ctl_in,
  input  tea_pkg::word_t      y_in,
  input  tea_pkg::word_t      z_in,
  input  tea_pkg::key_t       key,
  input  tea_pkg::word_t      sum_enc,
  input  tea_pkg::word_t      sum_dec,
  input  logic                odd,
  output tea_pkg::stage_ctl_t ctl,
  output tea_pkg::word_t      y,
  output tea_pkg::word_t      z
);
  import tea_pkg::*;

  logic  dec;
  logic  upd_y;
  word_t x;
  word_t ka;
  word_t kb;
  word_t sum;
  word_t target;
  word_t m;
  word_t res;

  always_comb begin
    dec    = (ctl_in.action == ACT_DECRYPT);
    upd_y  = (ctl_in.action == ACT_ENCRYPT) ^ odd;
    x      = upd_y ? z_in : y_in;
    ka     = upd_y ? key[0] : key[2];
    kb     = upd_y ? key[1] : key[3];
    sum    = dec ? sum_dec : sum_enc;
    target = upd_y ? y_in : z_in;
    m      = mix(x, sum, ka, kb);
    res    = dec ? target - m : target + m;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (en) begin
      ctl <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y <= upd_y ? res : y_in;
      z <= upd_y ? z_in : res;
    end
  end

endmodule

`default_nettype wire

// ===== sv/tea_checker.sv =====
// Port-level checks for the TEA block cipher, bound into the top level.
// Depends on tea_pkg for the word type and on tea_block_cipher for the bind.
`default_nettype none

module tea_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input tea_pkg::word_t out_left,
  input tea_pkg::word_t out_right
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_left) && $stable(out_right))
    else $error("Stalled output beat changed or vanished.");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("Output beat or stall right after reset.");

  a_ready_back: assert property (@(posedge clk) disable iff (rst)
    out_ready |=> in_ready)
    else $error("Input still stalled after the output was drained.");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("Input stalled with no output beat pending.");

endmodule

bind tea_block_cipher tea_checker u_tea_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (din.ready),
  .out_valid (dout.valid),
  .out_ready (dout.ready),
  .out_left  (dout.result_left),
  .out_right (dout.result_right)
);

`default_nettype wire
